// ----- rtl/i2cseq_pkg.sv -----
`default_nettype none

package i2cseq_pkg;

	// Field widths fixed by the command and response formats.
	localparam int WLEN_W = 5;
	localparam int RLEN_W = 8;

	// Longest read that one transaction may request.
	localparam logic [RLEN_W-1:0] MAX_READ = 8'd255;

	// Command function codes.
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_DONE  = 2'd2;

	// Bus actions requested from the bit-level engine.
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_START   = 3'd1;
	localparam logic [2:0] ACT_TX      = 3'd2;
	localparam logic [2:0] ACT_RESTART = 3'd3;
	localparam logic [2:0] ACT_STOP    = 3'd4;
	localparam logic [2:0] ACT_ACKBIT  = 3'd5;
	localparam logic [2:0] ACT_RXEN    = 3'd6;

	// Reported status.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_BUSY  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	// Transaction phase, one-hot.
	typedef enum logic [8:0] {
		PH_IDLE    = 9'b000000001,
		PH_START   = 9'b000000010,
		PH_WRITE   = 9'b000000100,
		PH_READ    = 9'b000001000,
		PH_RESTART = 9'b000010000,
		PH_ACK     = 9'b000100000,
		PH_NACK    = 9'b001000000,
		PH_STOP    = 9'b010000000,
		PH_ERROR   = 9'b100000000
	} phase_t;

	// One command beat.
	typedef struct packed {
		logic [1:0]        func;
		logic [7:0]        data_byte;
		logic [3:0]        byte_index;
		logic [6:0]        slave_address;
		logic [WLEN_W-1:0] write_length;
		logic [RLEN_W-1:0] read_length;
		logic              nack_seen;
	} cmd_t;

	// One response beat.
	typedef struct packed {
		logic [2:0] bus_action;
		logic [7:0] tx_byte;
		logic       ack_bit_value;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [7:0] rx_index;
		logic [1:0] status;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/i2c_master_transaction_sequencer_unit.sv -----
`default_nettype none

// Channel  Valid      Stall      Payload  Direction
// cmd      cmd_valid  cmd_stall  cmd      into the block
// rsp      rsp_valid  rsp_stall  rsp      out of the block
//
// Every command beat yields exactly one response beat, which passes through the command register
// and then the response register.
// A new command beat is taken in every cycle while the response side keeps up.
// The phase machine and write store update when a command leaves the command register.
// A stalled response holds the response register; an empty command register still takes
// a beat, while a full one stalls the command side.
// arst_n clears the phase and counters; the write store is not cleared.
module i2c_master_transaction_sequencer_unit #(
	parameter int WRITE_DEPTH = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cmd_valid,
	output logic                   cmd_stall,
	input  wire i2cseq_pkg::cmd_t  cmd,
	output logic                   rsp_valid,
	input  wire                    rsp_stall,
	output i2cseq_pkg::rsp_t       rsp
);
	import i2cseq_pkg::*;

	localparam int ADDR_W = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
	localparam logic [8:0] DEPTH_V = 9'(WRITE_DEPTH);

	// Command register and response register.
	logic              s1_valid_s1;
	cmd_t              cmd_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// Sequencer state.
	phase_t            phase_q, phase_d;
	logic [WLEN_W-1:0] wpos_q, wpos_d;
	logic [RLEN_W-1:0] rpos_q, rpos_d;
	logic [6:0]        target_q, target_d;
	logic [WLEN_W-1:0] writes_q, writes_d;
	logic [RLEN_W-1:0] reads_q, reads_d;
	logic [7:0]        store_q [WRITE_DEPTH];

	logic              advance;
	logic              s1_go;
	logic              cmd_take;
	logic              store_we;
	logic [WLEN_W-1:0] wlen_sat;
	logic [RLEN_W-1:0] rlen_sat;
	logic [RLEN_W-1:0] rpos_inc;
	logic              wr_more;
	rsp_t              rsp_d;

	// Handshake: the response register moves when empty or taken.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign s1_go     = s1_valid_s1 && advance;
	assign cmd_stall = s1_valid_s1 && !advance;
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Helper terms for the next-state logic.
	assign wlen_sat = (9'(cmd_s1.write_length) > DEPTH_V) ? WLEN_W'(DEPTH_V)
		: cmd_s1.write_length;
	assign rlen_sat = (cmd_s1.read_length > MAX_READ) ? MAX_READ : cmd_s1.read_length;
	assign rpos_inc = rpos_q + 8'd1;
	assign wr_more  = (wpos_q < writes_q) && (9'(wpos_q) < DEPTH_V);
	assign store_we = s1_go && (cmd_s1.func == FUNC_LOAD)
		&& (9'(cmd_s1.byte_index) < DEPTH_V);

	// Next phase and response for the command in the command register.
	always_comb begin
		phase_d  = phase_q;
		wpos_d   = wpos_q;
		rpos_d   = rpos_q;
		target_d = target_q;
		writes_d = writes_q;
		reads_d  = reads_q;
		rsp_d    = '0;
		case (cmd_s1.func)
			FUNC_START: begin
				if (phase_q == PH_IDLE || phase_q == PH_ERROR) begin
					target_d = cmd_s1.slave_address;
					writes_d = wlen_sat;
					reads_d  = rlen_sat;
					if (wlen_sat == '0 && rlen_sat == '0) begin
						phase_d = PH_ERROR;
					end else begin
						phase_d = PH_START;
						rsp_d.bus_action = ACT_START;
					end
				end
			end
			FUNC_DONE: begin
				case (phase_q)
					PH_START: begin
						wpos_d = '0;
						rpos_d = '0;
						rsp_d.bus_action = ACT_TX;
						if (writes_q != '0) begin
							phase_d = PH_WRITE;
							rsp_d.tx_byte = {target_q, 1'b0};
						end else begin
							phase_d = PH_ACK;
							rsp_d.tx_byte = {target_q, 1'b1};
						end
					end
					PH_WRITE: begin
						if (cmd_s1.nack_seen) begin
							phase_d = PH_ERROR;
						end else if (wr_more) begin
							rsp_d.bus_action = ACT_TX;
							rsp_d.tx_byte = store_q[ADDR_W'(wpos_q)];
							wpos_d = wpos_q + 5'd1;
						end else if (reads_q != '0) begin
							phase_d = PH_RESTART;
							rsp_d.bus_action = ACT_RESTART;
						end else begin
							phase_d = PH_STOP;
							rsp_d.bus_action = ACT_STOP;
						end
					end
					PH_RESTART: begin
						phase_d = PH_ACK;
						rsp_d.bus_action = ACT_TX;
						rsp_d.tx_byte = {target_q, 1'b1};
					end
					PH_READ: begin
						rsp_d.rx_valid = 1'b1;
						rsp_d.rx_byte = cmd_s1.data_byte;
						rsp_d.rx_index = rpos_q;
						rpos_d = rpos_inc;
						rsp_d.bus_action = ACT_ACKBIT;
						if (rpos_inc == reads_q) begin
							phase_d = PH_NACK;
							rsp_d.ack_bit_value = 1'b1;
						end else begin
							phase_d = PH_ACK;
						end
					end
					PH_ACK: begin
						phase_d = PH_READ;
						rsp_d.bus_action = ACT_RXEN;
					end
					PH_NACK: begin
						phase_d = PH_STOP;
						rsp_d.bus_action = ACT_STOP;
					end
					PH_STOP: begin
						phase_d = PH_IDLE;
					end
					default: begin
						phase_d = PH_ERROR;
					end
				endcase
			end
			default: begin
			end
		endcase
		case (phase_d)
			PH_IDLE:  rsp_d.status = ST_IDLE;
			PH_ERROR: rsp_d.status = ST_ERROR;
			default:  rsp_d.status = ST_BUSY;
		endcase
	end

	// Valid flags and sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			wpos_q      <= '0;
			rpos_q      <= '0;
			target_q    <= '0;
			writes_q    <= '0;
			reads_q     <= '0;
		end else begin
			if (cmd_take) begin
				s1_valid_s1 <= 1'b1;
			end else if (advance) begin
				s1_valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= s1_valid_s1;
			end
			if (s1_go) begin
				phase_q  <= phase_d;
				wpos_q   <= wpos_d;
				rpos_q   <= rpos_d;
				target_q <= target_d;
				writes_q <= writes_d;
				reads_q  <= reads_d;
			end
		end
	end

	// Payload registers and the write store.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_s1 <= cmd;
		end
		if (s1_go) begin
			rsp_q <= rsp_d;
		end
		if (store_we) begin
			store_q[ADDR_W'(cmd_s1.byte_index)] <= cmd_s1.data_byte;
		end
	end

`ifndef SYNTHESIS
	// A received byte is always paired with the ack bit for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.rx_valid |-> rsp.bus_action == ACT_ACKBIT)
		else $error("received byte without ack bit action");

	// A nack bit only goes out as an ack bit action.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ack_bit_value |-> rsp.bus_action == ACT_ACKBIT)
		else $error("nack value outside ack bit action");

	// A transmit byte is only nonzero on a transmit action.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bus_action != ACT_TX |-> rsp.tx_byte == 8'd0)
		else $error("tx byte set without transmit");

	// Reaching idle never asks for bus activity.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_IDLE |-> rsp.bus_action == ACT_NONE)
		else $error("bus action reported with idle status");

	// An empty command register never stalls the command side.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_s1 |-> !cmd_stall)
		else $error("stall with empty command register");
`endif

endmodule

`default_nettype wire

// ----- test/i2cseq_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the sequencer, predicts the response to every
// accepted command beat and compares each accepted response beat with the
// oldest prediction still waiting.
module i2cseq_checker #(
	parameter int WRITE_DEPTH = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cmd_valid,
	input  wire              cmd_stall,
	input  i2cseq_pkg::cmd_t cmd,
	input  wire              rsp_valid,
	input  wire              rsp_stall,
	input  i2cseq_pkg::rsp_t rsp,
	input  wire              wrap_up,
	output int               fail_count
);
	import i2cseq_pkg::*;

	// Shadow copy of the transaction state.
	phase_t            phase;
	logic [WLEN_W-1:0] wr_pos;
	logic [RLEN_W-1:0] rd_pos;
	logic [7:0]        wr_store [WRITE_DEPTH];
	logic [6:0]        tgt_addr;
	logic [WLEN_W-1:0] wr_want;
	logic [RLEN_W-1:0] rd_want;

	rsp_t pending_rsp [$];
	rsp_t want_rsp;
	int   fails = 0;
	int   rsp_count = 0;
	bit   wrapped = 1'b0;

	assign fail_count = fails;

	task automatic flag_error(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fails++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			flag_error($sformatf("response %0d %s got %0h want %0h",
				rsp_count, name, got, want));
	endtask

	// Moves the shadow state by one command beat and returns the response it causes.
	function automatic rsp_t advance_sequence(input cmd_t c);
		rsp_t r;
		int   wl;
		logic [RLEN_W-1:0] rl;
		r = '0;
		r.bus_action = ACT_NONE;
		case (c.func)
			FUNC_LOAD: begin
				if (int'(c.byte_index) < WRITE_DEPTH)
					wr_store[c.byte_index] = c.data_byte;
			end
			FUNC_START: begin
				// A start is only taken when no transaction is running.
				if (phase == PH_IDLE || phase == PH_ERROR) begin
					wl = (int'(c.write_length) > WRITE_DEPTH) ? WRITE_DEPTH
						: int'(c.write_length);
					rl = (c.read_length > MAX_READ) ? MAX_READ : c.read_length;
					tgt_addr = c.slave_address;
					wr_want = WLEN_W'(wl);
					rd_want = rl;
					if (wl == 0 && rl == 0) begin
						phase = PH_ERROR;
					end else begin
						phase = PH_START;
						r.bus_action = ACT_START;
					end
				end
			end
			FUNC_DONE: begin
				case (phase)
					PH_START: begin
						wr_pos = '0;
						rd_pos = '0;
						r.bus_action = ACT_TX;
						if (wr_want != 0) begin
							phase = PH_WRITE;
							r.tx_byte = {tgt_addr, 1'b0};
						end else begin
							phase = PH_ACK;
							r.tx_byte = {tgt_addr, 1'b1};
						end
					end
					PH_WRITE: begin
						if (c.nack_seen) begin
							phase = PH_ERROR;
						end else if (wr_pos < wr_want && int'(wr_pos) < WRITE_DEPTH) begin
							r.bus_action = ACT_TX;
							r.tx_byte = wr_store[wr_pos];
							wr_pos = wr_pos + 1'b1;
						end else if (rd_want != 0) begin
							phase = PH_RESTART;
							r.bus_action = ACT_RESTART;
						end else begin
							phase = PH_STOP;
							r.bus_action = ACT_STOP;
						end
					end
					PH_RESTART: begin
						phase = PH_ACK;
						r.bus_action = ACT_TX;
						r.tx_byte = {tgt_addr, 1'b1};
					end
					PH_READ: begin
						r.rx_valid = 1'b1;
						r.rx_byte = c.data_byte;
						r.rx_index = rd_pos;
						rd_pos = rd_pos + 1'b1;
						r.bus_action = ACT_ACKBIT;
						// The last byte of the read is answered with a nack.
						if (rd_pos == rd_want) begin
							phase = PH_NACK;
							r.ack_bit_value = 1'b1;
						end else begin
							phase = PH_ACK;
						end
					end
					PH_ACK: begin
						phase = PH_READ;
						r.bus_action = ACT_RXEN;
					end
					PH_NACK: begin
						phase = PH_STOP;
						r.bus_action = ACT_STOP;
					end
					PH_STOP: begin
						phase = PH_IDLE;
					end
					default: begin
						phase = PH_ERROR;
					end
				endcase
			end
			default: begin
			end
		endcase
		if (phase == PH_IDLE)
			r.status = ST_IDLE;
		else if (phase == PH_ERROR)
			r.status = ST_ERROR;
		else
			r.status = ST_BUSY;
		return r;
	endfunction

	// Predict on every command beat, compare on every response beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			wr_pos = '0;
			rd_pos = '0;
			tgt_addr = '0;
			wr_want = '0;
			rd_want = '0;
			pending_rsp.delete();
		end else begin
			if (cmd_valid && !cmd_stall)
				pending_rsp.push_back(advance_sequence(cmd));
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					flag_error($sformatf("response %0d arrived with none expected",
						rsp_count));
				end else begin
					want_rsp = pending_rsp.pop_front();
					compare_field("bus_action", 8'(rsp.bus_action), 8'(want_rsp.bus_action));
					compare_field("tx_byte", rsp.tx_byte, want_rsp.tx_byte);
					compare_field("ack_bit_value", 8'(rsp.ack_bit_value),
						8'(want_rsp.ack_bit_value));
					compare_field("rx_valid", 8'(rsp.rx_valid), 8'(want_rsp.rx_valid));
					compare_field("rx_byte", rsp.rx_byte, want_rsp.rx_byte);
					compare_field("rx_index", rsp.rx_index, want_rsp.rx_index);
					compare_field("status", 8'(rsp.status), 8'(want_rsp.status));
				end
				rsp_count++;
			end
			// Anything still waiting at the end never came out of the block.
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (pending_rsp.size() != 0)
					flag_error($sformatf("%0d responses never arrived", pending_rsp.size()));
			end
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import i2cseq_pkg::*;

	localparam int WRITE_DEPTH = 16;
	// Function code three has no meaning to the block.
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	cmd_t cmd = '0;
	logic cmd_stall;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic wrap_up = 1'b0;
	int   fail_count;

	int                   beats_sent = 0;
	int                   beats_back = 0;
	logic [1:0]           last_status = ST_IDLE;
	bit                   quiet = 1'b0;
	bit [WRITE_DEPTH-1:0] loaded = '0;

	i2c_master_transaction_sequencer_unit #(
		.WRITE_DEPTH(WRITE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	i2cseq_checker #(
		.WRITE_DEPTH(WRITE_DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.wrap_up(wrap_up),
		.fail_count(fail_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Count response beats and stall the response side at random.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			last_status = rsp.status;
			beats_back = beats_back + 1;
		end
		rsp_stall <= !quiet && ($urandom_range(0, 99) < 15);
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic cmd_t make_beat(input logic [1:0] func, input logic [7:0] data,
			input logic [3:0] idx, input logic [6:0] addr, input logic [4:0] wl,
			input logic [7:0] rl, input logic nack);
		cmd_t c;
		c.func = func;
		c.data_byte = data;
		c.byte_index = idx;
		c.slave_address = addr;
		c.write_length = wl;
		c.read_length = rl;
		c.nack_seen = nack;
		return c;
	endfunction

	// Shortens a write length so that only loaded store entries get sent.
	function automatic logic [4:0] safe_wlen(input int want);
		int n;
		int i;
		n = (want > WRITE_DEPTH) ? WRITE_DEPTH : want;
		for (i = 0; i < n; i++)
			if (!loaded[i])
				return 5'(i);
		return 5'(want);
	endfunction

	function automatic cmd_t random_beat();
		cmd_t c;
		c.func = 2'($urandom_range(0, 3));
		c.data_byte = 8'($urandom_range(0, 255));
		c.byte_index = 4'($urandom_range(0, 15));
		c.slave_address = 7'($urandom_range(0, 127));
		c.write_length = safe_wlen($urandom_range(0, 31));
		// Mostly short reads so that stray starts do not run for long.
		if ($urandom_range(0, 9) == 0)
			c.read_length = 8'($urandom_range(0, 255));
		else
			c.read_length = 8'($urandom_range(0, 3));
		c.nack_seen = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Drives one command beat and returns at the edge that accepts it.
	task automatic push_beat(input cmd_t c);
		while (!quiet && $urandom_range(0, 99) < 15) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		beats_sent++;
		if (c.func == FUNC_LOAD)
			loaded[c.byte_index] = 1'b1;
	endtask

	// Stops sending and waits until every beat sent has been answered.
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		wait (beats_back == beats_sent);
	endtask

	// Brings the block out of any transaction left running by random beats.
	task automatic settle();
		cmd_t c;
		drain();
		while (last_status == ST_BUSY) begin
			c = random_beat();
			c.func = FUNC_DONE;
			c.nack_seen = 1'b1;
			push_beat(c);
			drain();
		end
	endtask

	// One transaction with random content: a write, a read, or a write then a read.
	task automatic run_transaction();
		int   wl;
		int   rl;
		int   n;
		int   steps;
		int   k;
		bit   in_write;
		cmd_t c;
		case ($urandom_range(0, 9))
			0, 1: wl = 0;
			2: wl = $urandom_range(WRITE_DEPTH + 1, 31);
			default: wl = $urandom_range(1, WRITE_DEPTH);
		endcase
		k = $urandom_range(0, 99);
		if (k < 2)
			rl = $urandom_range(64, 255);
		else if (k < 15)
			rl = 0;
		else
			rl = $urandom_range(1, 6);
		n = (wl > WRITE_DEPTH) ? WRITE_DEPTH : wl;

		// Fill every byte that goes out; loaded ones are refreshed at random.
		for (k = 0; k < n; k++) begin
			if (!loaded[k] || $urandom_range(0, 1)) begin
				c = random_beat();
				c.func = FUNC_LOAD;
				c.byte_index = 4'(k);
				push_beat(c);
			end
		end
		c = random_beat();
		c.func = FUNC_START;
		c.write_length = 5'(wl);
		c.read_length = 8'(rl);
		push_beat(c);
		if (wl == 0 && rl == 0)
			return;

		// Completions up to and including the one that returns to idle.
		if (n > 0)
			steps = n + 2 + ((rl > 0) ? 2 * rl + 3 : 1);
		else
			steps = 2 * rl + 3;
		for (k = 1; k <= steps; k++) begin
			if ($urandom_range(0, 19) == 0) begin
				c = random_beat();
				c.func = FUNC_LOAD;
				push_beat(c);
			end
			c = random_beat();
			c.func = FUNC_DONE;
			in_write = n > 0 && k >= 2 && k <= n + 2;
			if (in_write)
				c.nack_seen = ($urandom_range(0, 99) < 3);
			push_beat(c);
			// A slave nack during the writes aborts the transaction.
			if (in_write && c.nack_seen)
				return;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Stray beats at idle, then an empty start.
		push_beat(make_beat(FUNC_SPARE, 8'hFF, 4'hF, 7'h7F, 5'd31, 8'hFF, 1'b1));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_START, 8'h00, 4'h0, 7'h7F, 5'd0, 8'h00, 1'b0));

		// Write one byte and read two, started from the error state.
		push_beat(make_beat(FUNC_LOAD, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_LOAD, 8'hFF, 4'hF, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_START, 8'h00, 4'h0, 7'h7F, 5'd1, 8'd2, 1'b0));
		push_beat(make_beat(FUNC_START, 8'h00, 4'h0, 7'h11, 5'd3, 8'd3, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b1));
		push_beat(make_beat(FUNC_LOAD, 8'h81, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b1));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'hFF, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));

		// Read only, to address zero.
		push_beat(make_beat(FUNC_START, 8'h00, 4'h0, 7'h00, 5'd0, 8'd1, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'hA5, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));

		// Slave nack on the address byte of a write.
		push_beat(make_beat(FUNC_START, 8'h00, 4'h0, 7'h2A, 5'd1, 8'd0, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b0));
		push_beat(make_beat(FUNC_DONE, 8'h00, 4'h0, 7'h00, 5'd0, 8'h00, 1'b1));

		// Mostly whole transactions, with bursts of stray beats between them.
		while (beats_sent < 1950) begin
			quiet = beats_sent >= 800 && beats_sent < 1100;
			if ($urandom_range(0, 99) < 80) begin
				settle();
				run_transaction();
			end else begin
				repeat ($urandom_range(1, 4))
					push_beat(random_beat());
			end
		end
		quiet = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
